FILE: sv/rainbow_led_strip_animator_defines.svh
// assertion helpers shared by the block
`ifndef RAINBOW_LED_STRIP_ANIMATOR_DEFINES_SVH
`define RAINBOW_LED_STRIP_ANIMATOR_DEFINES_SVH

// same-cycle implication
`define RLSA_ASSERT_SAME(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define RLSA_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: sv/rlsa_pkg.sv
package rlsa_pkg;

  localparam int NUM_LEDS_DEF       = 18;
  localparam int GRADIENT_STEPS_DEF = 180;

  localparam int SPEED_W     = 16;
  localparam int PHASE_W     = 16;
  localparam int LED_IDX_W   = 5;
  localparam int CHAN_W      = 8;
  localparam int RGB_W       = 3 * CHAN_W;
  localparam int FRAC_W      = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int HUE_SPAN    = 179;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd384;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 4'd1;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
  } frame_cmd_t;

  // hue in two-degree units (180 per turn) to a fully saturated color, {r, g, b}
  function automatic logic [RGB_W-1:0] hue_rgb(input int unsigned h);
    int unsigned m;
    int unsigned d;
    logic [CHAN_W-1:0] v;
    logic [RGB_W-1:0] rgb;
    m = h % 60;
    d = (m >= 30) ? (m - 30) : (30 - m);
    v = CHAN_W'((255 * (30 - d)) / 30);
    case ((h / 30) % 6)
      0: rgb = {8'd255, v, 8'd0};
      1: rgb = {v, 8'd255, 8'd0};
      2: rgb = {8'd0, 8'd255, v};
      3: rgb = {8'd0, v, 8'd255};
      4: rgb = {v, 8'd0, 8'd255};
      default: rgb = {8'd255, 8'd0, v};
    endcase
    return rgb;
  endfunction

  // floor(((256 - t) * a + t * b) / 256) as a + floor(t * (b - a) / 256)
  function automatic logic [CHAN_W-1:0] blend8(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [FRAC_W-1:0] t);
    logic signed [CHAN_W:0] diff;
    logic signed [CHAN_W+FRAC_W+1:0] prod;
    logic signed [CHAN_W+1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    sum  = $signed({2'b00, a}) + (CHAN_W+2)'(prod >>> FRAC_W);
    return sum[CHAN_W-1:0];
  endfunction

endpackage

FILE: sv/rlsa_ifs.sv
interface rlsa_in_if import rlsa_pkg::*; ();
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface rlsa_out_if import rlsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LED_IDX_W-1:0] led_index;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic                 last_led;
  modport source (output valid, output led_index, output red, output green,
                  output blue, output last_led, input ready);
  modport sink (input valid, input led_index, input red, input green,
                input blue, input last_led, output ready);
endinterface

interface rlsa_cfg_if import rlsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/rlsa_front.sv
module rlsa_front import rlsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rlsa_in_if.sink    in_ch,
  rlsa_cfg_if.sink   cfg_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output frame_cmd_t push_cmd
);

  logic [SPEED_W-1:0] speed_r;
  logic               enabled_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;

  // ticks with the bit clear or while disabled are dropped here
  assign push_valid     = in_ch.valid && in_ch.ready && in_ch.tick && enabled_r;
  assign push_cmd.speed = speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= SPEED_RESET;
      enabled_r <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_SPEED:   speed_r   <= cfg_ch.data[SPEED_W-1:0];
        REG_ENABLED: enabled_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/rlsa_queue.sv
module rlsa_queue import rlsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  frame_cmd_t wr_cmd,
  output logic       rd_valid,
  input  logic       rd_ready,
  output frame_cmd_t rd_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_cmd_t         ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = ent_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/rlsa_back.sv
module rlsa_back import rlsa_pkg::*; #(
  parameter int NUM_LEDS       = NUM_LEDS_DEF,
  parameter int GRADIENT_STEPS = GRADIENT_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  frame_cmd_t cmd,
  rlsa_out_if.source out_ch
);

  localparam int SPAN      = GRADIENT_STEPS * 256;
  localparam int POS_W     = PHASE_W + 1;
  localparam int SUM_W     = PHASE_W + 2;
  localparam int SUM_MAX   = SPAN - 1 + (2 ** SPEED_W) - 1;
  localparam int MOD_STEPS = $clog2((SUM_MAX / SPAN) + 1);
  localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int DIV_INIT  = SPAN * (2 ** (MOD_STEPS - 1));
  localparam int IDX_W     = $clog2(GRADIENT_STEPS);
  localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int REM_W     = $clog2(2 * NUM_LEDS);
  localparam int OFF_Q     = SPAN / NUM_LEDS;
  localparam int OFF_R     = SPAN % NUM_LEDS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WRAP = 2'd2;

  logic [RGB_W-1:0] grad_w [GRADIENT_STEPS];

  for (genvar k = 0; k < GRADIENT_STEPS; k++) begin : g_grad
    localparam int unsigned HUE = (HUE_SPAN * k) / GRADIENT_STEPS;
    assign grad_w[k] = hue_rgb(HUE);
  end

  logic [1:0]         state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [LED_W-1:0]   led_r, led_nxt;
  logic [PHASE_W-1:0] off_r, off_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   div_r, div_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic               s1_valid_r;
  logic [IDX_W-1:0]   s1_i0_r, s1_i1_r;
  logic [FRAC_W-1:0]  s1_t_r;
  logic [LED_W-1:0]   s1_led_r;
  logic               s1_last_r;

  logic               s2_valid_r;
  logic [RGB_W-1:0]   s2_a_r, s2_b_r;
  logic [FRAC_W-1:0]  s2_t_r;
  logic [LED_W-1:0]   s2_led_r;
  logic               s2_last_r;

  logic                 out_valid_r;
  logic [LED_IDX_W-1:0] out_led_r;
  logic [CHAN_W-1:0]    out_red_r, out_green_r, out_blue_r;
  logic                 out_last_r;

  logic               advance;
  logic               issue;
  logic               last_issue;
  logic [POS_W-1:0]   pos_raw;
  logic [POS_W-1:0]   pos;
  logic [IDX_W-1:0]   i0;
  logic [IDX_W-1:0]   i1;
  logic [REM_W-1:0]   rem_sum;
  logic [SUM_W-1:0]   sum_red;

  assign advance    = !out_valid_r || out_ch.ready;
  assign issue      = (state_r == ST_RUN) && advance;
  assign last_issue = (led_r == LED_W'(NUM_LEDS - 1));
  assign cmd_ready  = (state_r == ST_IDLE);

  // sample point of the current led
  assign pos_raw = {1'b0, phase_r} + {1'b0, off_r};
  assign pos     = (pos_raw >= POS_W'(SPAN)) ? pos_raw - POS_W'(SPAN) : pos_raw;
  assign i0      = pos[FRAC_W +: IDX_W];
  assign i1      = (i0 == IDX_W'(GRADIENT_STEPS - 1)) ? '0 : i0 + 1'b1;

  assign rem_sum = rem_r + REM_W'(OFF_R);
  assign sum_red = (sum_r >= div_r) ? sum_r - div_r : sum_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    speed_nxt = speed_r;
    led_nxt   = led_r;
    off_nxt   = off_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          speed_nxt = cmd.speed;
          led_nxt   = '0;
          off_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (last_issue) begin
            sum_nxt   = SUM_W'(phase_r) + SUM_W'(speed_r);
            div_nxt   = SUM_W'(DIV_INIT);
            step_nxt  = STEP_W'(MOD_STEPS - 1);
            state_nxt = ST_WRAP;
          end else begin
            led_nxt = led_r + 1'b1;
            if (rem_sum >= REM_W'(NUM_LEDS)) begin
              rem_nxt = rem_sum - REM_W'(NUM_LEDS);
              off_nxt = PHASE_W'(POS_W'(off_r) + POS_W'(OFF_Q) + 1'b1);
            end else begin
              rem_nxt = rem_sum;
              off_nxt = PHASE_W'(POS_W'(off_r) + POS_W'(OFF_Q));
            end
          end
        end
      end
      ST_WRAP: begin
        // restoring reduction of phase + speed modulo the table span
        sum_nxt = sum_red;
        div_nxt = div_r >> 1;
        if (step_r == '0) begin
          phase_nxt = sum_red[PHASE_W-1:0];
          state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (advance) begin
        s1_valid_r  <= issue;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    led_r   <= led_nxt;
    off_r   <= off_nxt;
    rem_r   <= rem_nxt;
    sum_r   <= sum_nxt;
    div_r   <= div_nxt;
    step_r  <= step_nxt;
    if (advance) begin
      s1_i0_r   <= i0;
      s1_i1_r   <= i1;
      s1_t_r    <= pos[FRAC_W-1:0];
      s1_led_r  <= led_r;
      s1_last_r <= last_issue;

      s2_a_r    <= grad_w[s1_i0_r];
      s2_b_r    <= grad_w[s1_i1_r];
      s2_t_r    <= s1_t_r;
      s2_led_r  <= s1_led_r;
      s2_last_r <= s1_last_r;

      out_led_r   <= LED_IDX_W'(s2_led_r);
      out_red_r   <= blend8(s2_a_r[2*CHAN_W +: CHAN_W], s2_b_r[2*CHAN_W +: CHAN_W], s2_t_r);
      out_green_r <= blend8(s2_a_r[CHAN_W +: CHAN_W], s2_b_r[CHAN_W +: CHAN_W], s2_t_r);
      out_blue_r  <= blend8(s2_a_r[0 +: CHAN_W], s2_b_r[0 +: CHAN_W], s2_t_r);
      out_last_r  <= s2_last_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.led_index = out_led_r;
  assign out_ch.red       = out_red_r;
  assign out_ch.green     = out_green_r;
  assign out_ch.blue      = out_blue_r;
  assign out_ch.last_led  = out_last_r;

endmodule

FILE: sv/rainbow_led_strip_animator.sv
// Rainbow LED strip animator.
// in_ch carries frame ticks (valid/ready, tick bit). A tick with the bit set,
// taken while enabled, starts one frame: out_ch then delivers NUM_LEDS colors
// in LED order, led_index from 0, last_led high on the final one. Other ticks
// are taken and dropped. cfg_ch writes speed (index 0, Q8 steps per frame) and
// enabled (index 1); other indexes are ignored, writes are always ready.
// Accepted frames wait in a two-entry queue; in_ch.ready drops while it is full.
// The first color of a frame passes the queue, the frame engine and the s1, s2
// and output registers before it is valid. The frame engine issues one LED
// per cycle while out_ch is not stalled, then reduces the new phase modulo the
// table span and takes the next frame from the queue only once it is idle.
// A stalled receiver freezes the three-stage color pipeline in place; no color
// is lost or repeated and the held output stays stable.
// Reset (synchronous, rst_n low) clears the phase, empties the queue, drops any
// frame in flight, and restores speed 1.5 steps and enabled.
`include "rainbow_led_strip_animator_defines.svh"

module rainbow_led_strip_animator import rlsa_pkg::*; #(
  parameter int NUM_LEDS       = NUM_LEDS_DEF,
  parameter int GRADIENT_STEPS = GRADIENT_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rlsa_in_if.sink     in_ch,
  rlsa_out_if.source  out_ch,
  rlsa_cfg_if.sink    cfg_ch
);

  logic       q_push_valid;
  logic       q_push_ready;
  frame_cmd_t q_push_cmd;
  logic       q_pop_valid;
  logic       q_pop_ready;
  frame_cmd_t q_pop_cmd;

  rlsa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  rlsa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_push_valid),
    .wr_ready (q_push_ready),
    .wr_cmd   (q_push_cmd),
    .rd_valid (q_pop_valid),
    .rd_ready (q_pop_ready),
    .rd_cmd   (q_pop_cmd)
  );

  rlsa_back #(
    .NUM_LEDS       (NUM_LEDS),
    .GRADIENT_STEPS (GRADIENT_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_pop_valid),
    .cmd_ready (q_pop_ready),
    .cmd       (q_pop_cmd),
    .out_ch    (out_ch)
  );

  `RLSA_ASSERT_SAME(a_last_index, out_ch.valid && out_ch.last_led, out_ch.led_index == LED_IDX_W'(NUM_LEDS - 1), "last_led on wrong led")
  `RLSA_ASSERT_NEXT(a_frame_contiguous, out_ch.valid && out_ch.ready && !out_ch.last_led, out_ch.valid, "gap inside a frame")
  `RLSA_ASSERT_NEXT(a_engine_busy, q_pop_valid && q_pop_ready, !q_pop_ready, "engine took two frames in a row")

endmodule
